// ----- design/bole_pkg.sv -----
// Shared types and codes for the bounded ordered list engine.
// No dependencies; used by bole_cell and bounded_ordered_list_engine.
package bole_pkg;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_KEY  = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_TAIL = 3'd4,
        OP_DEL_KEY  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // How a cell decides whether it is the position that the request targets.
    typedef enum logic [1:0] {
        SEL_HEAD     = 2'd0,
        SEL_TAIL_INS = 2'd1,
        SEL_TAIL_DEL = 2'd2,
        SEL_KEY      = 2'd3
    } sel_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic insert;   // 1: shift up and place new word, 0: shift down
        sel_t sel;
    } cell_cmd_t;

endpackage

// ----- design/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine: request decode, entry count,
// result register, and the row of bole_cell entries. Depends on bole_pkg.
//
// The engine keeps an ordered list of up to CAPACITY words of DATA_WIDTH bits
// in a row of cells, one entry per cell, plus an entry count. Each request
// item carries an operation (insert at head, insert at tail, insert before
// the first entry equal to match_key, delete at head, delete at tail, delete
// the first entry equal to match_key), and yields exactly one result item
// with a status (done, full, empty, key not found) and the count afterwards.
// Every cell compares its word against the key at once; the first hit is
// passed down the row as a "position already claimed" signal, and each cell
// then loads its left neighbor, its right neighbor, the new word, or keeps
// its own. A request is therefore finished in the cycle it is accepted: one
// item per clock is sustained while results are taken; results are registered.
// The request path is stalled only when the result register is full and not
// being taken. The key search ripples through the row, so the longest path
// grows with CAPACITY. Inputs wider than DATA_WIDTH are cut to their low
// DATA_WIDTH bits before storing or comparing; entry_count reports the low
// four bits of the count. Unused operation codes change nothing and report
// done.
module bounded_ordered_list_engine #(
    parameter int CAPACITY   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic signed [31:0] s_new_value,
    input  logic signed [31:0] s_match_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [3:0]         m_entry_count
);
    import bole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    status_t               m_status_reg;
    logic [3:0]            m_entry_count_reg;

    logic signed [63:0]    word_ext;
    logic signed [63:0]    key_ext;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] key;

    logic                  accept;
    logic                  found;
    status_t               status;
    logic                  change;
    logic                  commit;
    cell_cmd_t             cmd;
    logic [CNT_W+3:0]      count_wide;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic                  after_chain [CAPACITY+1];

    // Signed inputs are sign-extended, then cut to the stored word width.
    assign word_ext = 64'(s_new_value);
    assign key_ext  = 64'(s_match_key);
    assign word     = word_ext[DATA_WIDTH-1:0];
    assign key      = key_ext[DATA_WIDTH-1:0];

    // The result register frees up in the same cycle it is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // The last cell's chain output tells whether any held entry matched.
    assign found = after_chain[CAPACITY];

    // The cell command depends on the operation alone, so the search result
    // that comes back from the row never feeds into it.
    always_comb begin
        cmd.insert = 1'b1;
        cmd.sel    = SEL_HEAD;
        case (s_operation)
            OP_INS_HEAD: begin
                cmd.sel = SEL_HEAD;
            end
            OP_INS_TAIL: begin
                cmd.sel = SEL_TAIL_INS;
            end
            OP_INS_KEY: begin
                cmd.sel = SEL_KEY;
            end
            OP_DEL_HEAD: begin
                cmd.insert = 1'b0;
            end
            OP_DEL_TAIL: begin
                cmd.insert = 1'b0;
                cmd.sel    = SEL_TAIL_DEL;
            end
            OP_DEL_KEY: begin
                cmd.insert = 1'b0;
                cmd.sel    = SEL_KEY;
            end
            default: begin
                cmd.sel = SEL_HEAD;
            end
        endcase
    end

    // Decode the request: status and whether state moves.
    always_comb begin
        status     = ST_DONE;
        change     = 1'b0;
        count_next = count_reg;
        case (s_operation)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_KEY: begin
                if (count_reg == CNT_W'(CAPACITY)) begin
                    status = ST_FULL;
                end else if (cmd.sel == SEL_KEY && !found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    change     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_KEY: begin
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else if (cmd.sel == SEL_KEY && !found) begin
                    status = ST_NOT_FOUND;
                end else begin
                    change     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
        commit = accept && change;
    end

    assign after_chain[0] = 1'b0;

    // The row of entries. Cell zero's left neighbor is never selected and is tied
    // to the new word; the last cell's right neighbor is tied to zero.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = word;
        end else begin : g_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_right
            assign right_data = cell_data[i+1];
        end

        bole_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .commit     (commit),
            .count      (count_reg),
            .key        (key),
            .new_data   (word),
            .left_data  (left_data),
            .right_data (right_data),
            .after_in   (after_chain[i]),
            .after_out  (after_chain[i+1]),
            .data_out   (cell_data[i])
        );
    end

    assign count_wide = {4'b0000, count_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg      <= status;
            m_entry_count_reg <= count_wide[3:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule

// ----- design/bole_cell.sv -----
// One entry of the list: stored word, key compare and shift selection.
// Depends on bole_pkg; instantiated in a row by bounded_ordered_list_engine.
module bole_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 4
) (
    input  logic                  aclk,
    input  bole_pkg::cell_cmd_t   cmd,
    input  logic                  commit,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic [DATA_WIDTH-1:0] new_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  after_in,
    output logic                  after_out,
    output logic [DATA_WIDTH-1:0] data_out
);
    import bole_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  held;
    logic                  at_pos;

    assign held = (count > CNT_W'(INDEX));

    always_comb begin
        case (cmd.sel)
            SEL_HEAD:     at_pos = (INDEX == 0);
            SEL_TAIL_INS: at_pos = (count == CNT_W'(INDEX));
            SEL_TAIL_DEL: at_pos = (count == CNT_W'(INDEX + 1));
            SEL_KEY:      at_pos = held && (data_reg == key) && !after_in;
            default:      at_pos = 1'b0;
        endcase
    end

    // The first matching cell claims the position; every later cell sees it.
    assign after_out = after_in | at_pos;

    always_comb begin
        data_next = data_reg;
        if (cmd.insert) begin
            if (at_pos) begin
                data_next = new_data;
            end else if (after_in) begin
                data_next = left_data;
            end
        end else if (at_pos || after_in) begin
            data_next = right_data;
        end
    end

    // The stored entries are updated only in a cycle that changes the list.
    always_ff @(posedge aclk) begin
        if (commit) begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule
